// ===== sv/lru_pkg.sv =====
// Shared types and constants for the LRU frame replacement block.
// No dependencies; every other file imports this package.
package lru_pkg;

    localparam int FRAME_W        = 6;
    localparam int STATUS_W       = 2;
    localparam int DEFAULT_FRAMES = 64;

    typedef logic [FRAME_W-1:0]  t_frame;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_REF_DONE = 2'd0;
    localparam t_status STATUS_EVICTED  = 2'd1;
    localparam t_status STATUS_EMPTY    = 2'd2;

    // Token that walks down the cell chain during a reference.
    // carry: frame to store in the next cell, key: frame being referenced.
    typedef struct packed {
        logic   vld;
        t_frame carry;
        t_frame key;
    } t_token;

endpackage

// ===== sv/lru_req_if.sv =====
// Request channel: valid/ready handshake carrying mode and frame number.
// Depends on lru_pkg.
interface lru_req_if
    import lru_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   mode;
    t_frame frame_num;

    modport source (output valid, output mode, output frame_num, input ready);
    modport sink   (input valid, input mode, input frame_num, output ready);
endinterface

// ===== sv/lru_rsp_if.sv =====
// Response channel: valid/ready handshake carrying victim frame and status.
// Depends on lru_pkg.
interface lru_rsp_if
    import lru_pkg::*;
();
    logic    valid;
    logic    ready;
    t_frame  victim_frame;
    t_status status;

    modport source (output valid, output victim_frame, output status, input ready);
    modport sink   (input valid, input victim_frame, input status, output ready);
endinterface

// ===== sv/lru_frame_replacement.sv =====
// Top level of the LRU frame replacement block: request/response control
// and a chain of lru_cell instances. Depends on lru_pkg, lru_req_if,
// lru_rsp_if and lru_cell.
//
// The order is kept in a chain of FRAMES cells with the most recently used
// frame in cell 0 and the least recently used in the last valid cell. An
// evict, or a reference to a frame number not below FRAMES, has its response
// registered on acceptance, and such transactions can be accepted every
// cycle while no walk is in progress and the response slot is free or being
// read. A reference pushes a token into cell 0 that moves one cell per
// cycle, shifting frames toward the tail until it reaches the cell holding
// the frame or the first empty cell, which absorbs it; no new request is
// accepted before the response is registered. Reset empties the order at
// once.
module lru_frame_replacement
    import lru_pkg::*;
#(
    parameter int FRAMES = DEFAULT_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lru_req_if.sink     i_req,
    lru_rsp_if.source   o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic    r_state;
    logic    n_state;
    logic    r_out_vld;
    t_frame  r_out_victim;
    t_status r_out_status;

    t_token             tok_chain [FRAMES+1];
    logic [FRAMES-1:0]  cell_valid;
    logic [FRAMES-1:0]  cell_done;
    t_frame             cell_victim [FRAMES];

    logic   accept;
    logic   in_range;
    logic   evict;
    logic   done_any;
    t_frame victim;

    assign in_range = (32'(i_req.frame_num) < 32'(FRAMES));
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_vld || o_rsp.ready);
    assign accept   = i_req.valid && i_req.ready;
    assign evict    = accept && i_req.mode;
    assign done_any = |cell_done;

    always_comb begin
        tok_chain[0].vld   = accept && !i_req.mode && in_range;
        tok_chain[0].carry = i_req.frame_num;
        tok_chain[0].key   = i_req.frame_num;
    end

    always_comb begin
        victim = '0;
        for (int i = 0; i < FRAMES; i++) begin
            victim = victim | cell_victim[i];
        end
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic next_valid;
        if (g == FRAMES - 1) begin : g_last
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_valid = cell_valid[g+1];
        end
        lru_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (tok_chain[g]),
            .i_next_valid (next_valid),
            .i_evict      (evict),
            .o_tok        (tok_chain[g+1]),
            .o_valid      (cell_valid[g]),
            .o_done       (cell_done[g]),
            .o_victim     (cell_victim[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tok_chain[0].vld) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (done_any) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            priority if (done_any || (accept && (i_req.mode || !in_range))) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end else begin
                r_out_vld <= r_out_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (done_any) begin
            r_out_victim <= '0;
            r_out_status <= STATUS_REF_DONE;
        end else if (evict) begin
            // empty order when cell 0 holds nothing
            r_out_victim <= cell_valid[0] ? victim : '0;
            r_out_status <= cell_valid[0] ? STATUS_EVICTED : STATUS_EMPTY;
        end else if (accept) begin
            r_out_victim <= '0;
            r_out_status <= STATUS_REF_DONE;
        end else begin
            r_out_victim <= r_out_victim;
            r_out_status <= r_out_status;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.victim_frame = r_out_victim;
    assign o_rsp.status       = r_out_status;

    a_done_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_any |-> (r_state == ST_WALK))
        else $error("token absorbed outside a walk");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_done))
        else $error("more than one cell absorbed the token");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, cell_valid} + {{FRAMES{1'b0}}, 1'b1}))
        else $error("valid cells do not form a prefix");

    a_ref_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_chain[0].vld |=> (r_state == ST_WALK) && !r_out_vld)
        else $error("reference did not start a walk with a free output slot");

    a_chain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tok_chain[FRAMES].vld)
        else $error("token ran off the end of the chain");

endmodule

// ===== sv/lru_cell.sv =====
// One cell of the LRU chain: holds a frame number and a valid bit, and
// forwards its old frame to the next cell while a reference token passes.
// Depends on lru_pkg.
module lru_cell
    import lru_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    input  logic   i_next_valid,
    input  logic   i_evict,
    output t_token o_tok,
    output logic   o_valid,
    output logic   o_done,
    output t_frame o_victim
);

    logic   r_valid;
    t_frame r_frame;
    logic   r_tok_vld;
    t_frame r_tok_carry;
    t_frame r_tok_key;

    logic hit;
    logic tail;

    always_comb begin
        hit       = r_valid && (r_frame == r_tok_key);
        tail      = r_valid && !i_next_valid;
        // absorb the token on a match or at the first empty cell
        o_done    = r_tok_vld && (!r_valid || hit);
        o_tok.vld = r_tok_vld && r_valid && !hit;
        o_tok.carry = r_frame;
        o_tok.key   = r_tok_key;
        o_valid   = r_valid;
        o_victim  = tail ? r_frame : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok.vld;
            if (r_tok_vld) begin
                r_valid <= 1'b1;
            end else if (i_evict && tail) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_carry <= i_tok.carry;
        r_tok_key   <= i_tok.key;
        if (r_tok_vld) begin
            r_frame <= r_tok_carry;
        end
    end

endmodule
